// ===== rtl/core/quadratic_root_solver_assert.svh =====
// Assertion macros shared by the checker
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Clocked implication check, quiet while reset is held
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Clocked next-cycle implication check, quiet while reset is held
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/qrs_pkg.sv =====
package qrs_pkg;

	localparam int IN_W   = 16;            // coefficient width
	localparam int PROD_W = 2 * IN_W;      // b*b and a*c
	localparam int DISC_W = PROD_W + 2;    // b*b - 4*a*c
	localparam int MAG_W  = DISC_W;        // |disc|, even so it splits into bit pairs
	localparam int OUT_FRAC = 16;
	localparam int SQ_STEPS = MAG_W / 2 + OUT_FRAC;   // one result bit per round
	localparam int ROOT_W = SQ_STEPS;
	localparam int SQREM_W = ROOT_W + 3;
	localparam int NUM_W  = ROOT_W;        // divider dividend width
	localparam int DEN_W  = IN_W + 1;      // |2a|
	localparam int DREM_W = DEN_W + 1;
	localparam int OUT_W  = 48;

	typedef enum logic [1:0] {
		KIND_REAL   = 2'd0,
		KIND_DOUBLE = 2'd1,
		KIND_CPLX   = 2'd2,
		KIND_ERR    = 2'd3
	} qrs_kind_t;

	// Side information carried along with a division
	typedef struct packed {
		qrs_kind_t               kind;
		logic                    a_neg;
		logic                    k_neg;
		logic signed [OUT_W-1:0] k;
	} qrs_side_t;

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
// Pipeline: multiply, discriminant, 33 square-root rounds beside the k divider,
// 33 divider stages for d, output register.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or taken. arst_n clears all valid bits at once.
module quadratic_root_solver (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // root1_real, root1_imag, root2_real, root2_imag
	output logic [1:0]   m_tuser    // root_kind
);

	localparam int IW = qrs_pkg::IN_W;
	localparam int Q  = qrs_pkg::SQ_STEPS;
	localparam int OW = qrs_pkg::OUT_W;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: products
	logic                                 v_s1;
	logic signed [IW-1:0]                 a_s1, b_s1;
	logic signed [qrs_pkg::PROD_W-1:0]    bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= s_tdata[IW-1:0];
			b_s1  <= s_tdata[2*IW-1:IW];
			bb_s1 <= $signed(s_tdata[2*IW-1:IW]) * $signed(s_tdata[2*IW-1:IW]);
			ac_s1 <= $signed(s_tdata[IW-1:0]) * $signed(s_tdata[3*IW-1:2*IW]);
		end
	end

	// Stage 2: discriminant, case kind, magnitudes and signs
	logic signed [qrs_pkg::DISC_W-1:0] disc;
	qrs_pkg::qrs_kind_t                kind_c;
	logic [IW-1:0]                     b_mag;

	always_comb begin
		disc = qrs_pkg::DISC_W'(bb_s1) - (qrs_pkg::DISC_W'(ac_s1) <<< 2);
		if (a_s1 == '0)
			kind_c = qrs_pkg::KIND_ERR;
		else if (disc == '0)
			kind_c = qrs_pkg::KIND_DOUBLE;
		else if (disc > 0)
			kind_c = qrs_pkg::KIND_REAL;
		else
			kind_c = qrs_pkg::KIND_CPLX;
		b_mag = b_s1[IW-1] ? IW'(-b_s1) : IW'(b_s1);
	end

	logic                             v_s2;
	logic [qrs_pkg::MAG_W-1:0]        mag_s2;
	logic [qrs_pkg::DEN_W-1:0]        den_s2;
	logic [qrs_pkg::NUM_W-1:0]        knum_s2;
	qrs_pkg::qrs_side_t               side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2        <= disc[qrs_pkg::DISC_W-1] ? qrs_pkg::MAG_W'(-disc)
			                                         : qrs_pkg::MAG_W'(disc);
			den_s2        <= a_s1[IW-1] ? (qrs_pkg::DEN_W'(-a_s1) << 1)
			                            : (qrs_pkg::DEN_W'(a_s1) << 1);
			// |b| * 2^16, b = -32768 gives 2^31 which still fits
			knum_s2       <= qrs_pkg::NUM_W'(b_mag) << qrs_pkg::OUT_FRAC;
			side_s2.kind  <= kind_c;
			side_s2.a_neg <= a_s1[IW-1];
			// k = -b / 2a is negative when b and a share a sign
			side_s2.k_neg <= !(b_s1[IW-1] ^ a_s1[IW-1]);
			side_s2.k     <= '0;
		end
	end

	// Square root: one result bit per stage, two magnitude bits shifted in
	logic [qrs_pkg::MAG_W-1:0]   sq_mag_s  [0:Q];
	logic [qrs_pkg::SQREM_W-1:0] sq_rem_s  [0:Q];
	logic [qrs_pkg::ROOT_W-1:0]  sq_root_s [0:Q];

	assign sq_mag_s[0]  = mag_s2;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;

	for (genvar t = 1; t <= Q; t++) begin : g_sqrt
		logic [qrs_pkg::SQREM_W-1:0] rem_sh;
		logic [qrs_pkg::SQREM_W-1:0] trial;
		logic                        fit;

		always_comb begin
			rem_sh = {sq_rem_s[t-1][qrs_pkg::SQREM_W-3:0],
			          sq_mag_s[t-1][qrs_pkg::MAG_W-1 -: 2]};
			trial  = {1'b0, sq_root_s[t-1][qrs_pkg::SQREM_W-4:0], 2'b01};
			fit    = (rem_sh >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_mag_s[t]  <= {sq_mag_s[t-1][qrs_pkg::MAG_W-3:0], 2'b00};
				sq_rem_s[t]  <= fit ? (rem_sh - trial) : rem_sh;
				sq_root_s[t] <= {sq_root_s[t-1][qrs_pkg::ROOT_W-2:0], fit};
			end
		end
	end

	// k divider runs beside the square root
	logic                        kv;
	logic [qrs_pkg::NUM_W-1:0]   kq;
	logic [qrs_pkg::DEN_W-1:0]   kden;
	qrs_pkg::qrs_side_t          kside;
	qrs_pkg::qrs_side_t          dside_in;

	qrs_divpipe u_kdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_num    (knum_s2),
		.in_den    (den_s2),
		.in_side   (side_s2),
		.out_valid (kv),
		.out_quo   (kq),
		.out_den   (kden),
		.out_side  (kside)
	);

	// Attach signed k before the d division
	always_comb begin
		dside_in   = kside;
		dside_in.k = kside.k_neg ? -OW'(kq) : OW'(kq);
	end

	logic                        dv;
	logic [qrs_pkg::NUM_W-1:0]   dq;
	logic [qrs_pkg::DEN_W-1:0]   dden_unused;
	qrs_pkg::qrs_side_t          dside;

	qrs_divpipe u_ddiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (kv),
		.in_num    (sq_root_s[Q]),
		.in_den    (kden),
		.in_side   (dside_in),
		.out_valid (dv),
		.out_quo   (dq),
		.out_den   (dden_unused),
		.out_side  (dside)
	);

	// Combine k and d into the two roots
	logic signed [OW-1:0] d_c;
	logic signed [OW-1:0] r1r, r1i, r2r, r2i;

	always_comb begin
		d_c = dside.a_neg ? -OW'(dq) : OW'(dq);
		r1r = '0;
		r1i = '0;
		r2r = '0;
		r2i = '0;
		case (dside.kind)
			qrs_pkg::KIND_REAL: begin
				r1r = dside.k + d_c;
				r2r = dside.k - d_c;
			end
			qrs_pkg::KIND_DOUBLE: begin
				r1r = dside.k;
				r2r = dside.k;
			end
			qrs_pkg::KIND_CPLX: begin
				r1r = dside.k;
				r2r = dside.k;
				r1i = d_c;
				r2i = -d_c;
			end
			default: begin
				r1r = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv && (dden_unused == dden_unused);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {r2i, r2r, r1i, r1r};
			m_tuser <= dside.kind;
		end
	end

endmodule

// ===== rtl/core/qrs_divpipe.sv =====
module qrs_divpipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [qrs_pkg::NUM_W-1:0]    in_num,
	input  logic [qrs_pkg::DEN_W-1:0]    in_den,
	input  qrs_pkg::qrs_side_t           in_side,
	output logic                         out_valid,
	output logic [qrs_pkg::NUM_W-1:0]    out_quo,
	output logic [qrs_pkg::DEN_W-1:0]    out_den,
	output qrs_pkg::qrs_side_t           out_side
);

	localparam int N = qrs_pkg::NUM_W;

	logic                          v_s    [0:N];
	logic [qrs_pkg::NUM_W-1:0]     num_s  [0:N];
	logic [qrs_pkg::NUM_W-1:0]     quo_s  [0:N];
	logic [qrs_pkg::DREM_W-1:0]    rem_s  [0:N];
	logic [qrs_pkg::DEN_W-1:0]     den_s  [0:N];
	qrs_pkg::qrs_side_t            side_s [0:N];

	assign v_s[0]    = in_valid;
	assign num_s[0]  = in_num;
	assign quo_s[0]  = '0;
	assign rem_s[0]  = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	// One restoring step per stage, dividend bits taken from the top
	for (genvar t = 1; t <= N; t++) begin : g_step
		logic [qrs_pkg::DREM_W-1:0] rem_sh;
		logic                       fit;

		always_comb begin
			rem_sh = {rem_s[t-1][qrs_pkg::DREM_W-2:0], num_s[t-1][N-1]};
			fit    = (rem_sh >= {1'b0, den_s[t-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[t] <= 1'b0;
			end else if (en) begin
				v_s[t] <= v_s[t-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[t]  <= {num_s[t-1][N-2:0], 1'b0};
				quo_s[t]  <= {quo_s[t-1][N-2:0], fit};
				rem_s[t]  <= fit ? (rem_sh - {1'b0, den_s[t-1]}) : rem_sh;
				den_s[t]  <= den_s[t-1];
				side_s[t] <= side_s[t-1];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_quo   = quo_s[N];
	assign out_den   = den_s[N];
	assign out_side  = side_s[N];

endmodule

// ===== rtl/core/qrs_checker.sv =====
`include "quadratic_root_solver_assert.svh"

module qrs_sva (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic [1:0]   m_tuser
);

	`QRS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
	`QRS_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
	`QRS_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser == qrs_pkg::KIND_ERR, m_tdata == '0, "error beat carries nonzero roots")
	`QRS_ASSERT_IMP(a_real_imag, m_tvalid && m_tuser != qrs_pkg::KIND_CPLX, m_tdata[95:48] == '0 && m_tdata[191:144] == '0, "real roots with imaginary part")
	`QRS_ASSERT_IMP(a_cplx_conj, m_tvalid && m_tuser == qrs_pkg::KIND_CPLX, m_tdata[47:0] == m_tdata[143:96] && m_tdata[95:48] == -m_tdata[191:144], "complex pair not conjugate")

endmodule

bind quadratic_root_solver qrs_sva u_qrs_sva (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/qrs_checker.sv =====
`timescale 1ns / 100ps

module qrs_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [47:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           fail_count,
	output int           roots_pending
);

	typedef struct packed {
		logic [47:0]          r1r;
		logic [47:0]          r1i;
		logic [47:0]          r2r;
		logic [47:0]          r2i;
		qrs_pkg::qrs_kind_t   kind;
	} roots_t;

	roots_t expected_roots[$];

	// floor(sqrt(mag * 2^32)), two bits per round
	function automatic longint unsigned isqrt_scaled(longint unsigned mag);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned pair;
		longint unsigned trial;
		rem = 0;
		root = 0;
		for (int i = 16; i >= -16; i--) begin
			pair = (i >= 0) ? ((mag >> (2 * i)) & 64'd3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint clamp48(longint v);
		longint hi;
		hi = (longint'(1) <<< 47) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic roots_t solve_roots(logic [47:0] coefs);
		roots_t r;
		longint a;
		longint b;
		longint c;
		longint disc;
		longint two_a;
		longint k;
		longint d;
		longint s;
		a = longint'($signed(coefs[15:0]));
		b = longint'($signed(coefs[31:16]));
		c = longint'($signed(coefs[47:32]));
		r = '0;
		if (a == 0) begin
			r.kind = qrs_pkg::KIND_ERR;
		end else begin
			disc = b * b - 4 * a * c;
			two_a = 2 * a;
			k = (-b * 65536) / two_a;
			r.r1r = 48'(clamp48(k));
			r.r2r = 48'(clamp48(k));
			if (disc == 0) begin
				r.kind = qrs_pkg::KIND_DOUBLE;
			end else begin
				s = longint'(isqrt_scaled((disc < 0) ? -disc : disc));
				d = s / two_a;
				if (disc > 0) begin
					r.kind = qrs_pkg::KIND_REAL;
					r.r1r = 48'(clamp48(k + d));
					r.r2r = 48'(clamp48(k - d));
				end else begin
					r.kind = qrs_pkg::KIND_CPLX;
					r.r1i = 48'(clamp48(d));
					r.r2i = 48'(clamp48(-d));
				end
			end
		end
		return r;
	endfunction

	assign roots_pending = expected_roots.size();

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		roots_t want;
		roots_t got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_roots.push_back(solve_roots(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[47:0], m_tdata[95:48], m_tdata[143:96],
					m_tdata[191:144], qrs_pkg::qrs_kind_t'(m_tuser)};
				if (expected_roots.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat %h kind %0d", m_tdata, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_roots.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: exp r1 %h+%hi r2 %h+%hi k%0d, got r1 %h+%hi r2 %h+%hi k%0d",
								want.r1r, want.r1i, want.r2r, want.r2i, want.kind,
								got.r1r, got.r1i, got.r2r, got.r2i, got.kind);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb_quadratic_root_solver.sv =====
`timescale 1ns / 100ps

module tb_quadratic_root_solver;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic [1:0]   m_tuser;
	int           fail_count;
	int           roots_pending;
	int           idle_cycles = 0;
	bit           calm_phase;

	localparam int WATCHDOG_LIMIT = 2000;

	quadratic_root_solver dut (.*);

	qrs_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// coefficient picker: extremes, small values, multiples of 256, noise
	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 16)) - 8);
			3: return 16'($urandom_range(0, 255)) << 8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		int gap;
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// random stalls on the result side
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (calm_phase) begin
				m_tready <= 1'b1;
			end else if (m_tready && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// count cycles with no accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_quadratic_root_solver: done, errors");
			$finish;
		end
	end

	initial begin
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		int r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm_phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, a zero, double root, complex, negative a
		send_coefs(16'h0000, 16'h1234, 16'h0100);
		send_coefs(16'h0000, 16'h0000, 16'h0000);
		send_coefs(16'h0100, 16'hfe00, 16'h0100);
		send_coefs(16'h0100, 16'h0000, 16'h0100);
		send_coefs(16'h0100, 16'h0000, 16'hff00);
		send_coefs(16'hff00, 16'h0300, 16'hfe00);
		send_coefs(16'hff00, 16'h0000, 16'hff00);
		send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
		send_coefs(16'h8000, 16'h8000, 16'h8000);
		send_coefs(16'h7fff, 16'h8000, 16'h8000);
		send_coefs(16'h8000, 16'h7fff, 16'h7fff);
		send_coefs(16'h0001, 16'h7fff, 16'h8000);
		send_coefs(16'h0001, 16'h8000, 16'h7fff);
		send_coefs(16'hffff, 16'h0001, 16'hffff);
		send_coefs(16'h0001, 16'h0002, 16'h0001);
		send_coefs(16'hffff, 16'hffff, 16'hffff);
		send_coefs(16'h0001, 16'h0000, 16'h0000);
		send_coefs(16'hffff, 16'h0000, 16'h0000);
		send_coefs(16'h8000, 16'h0000, 16'h7fff);
		send_coefs(16'h5555, 16'haaaa, 16'h5555);
		// random: mix of double-root builds, zero-a cases and free coefficients
		for (int i = 0; i < 1400; i++) begin
			if (i == 1200) calm_phase = 1;
			a = pick_coef();
			c = pick_coef();
			b = pick_coef();
			r = $urandom_range(0, 7);
			if (r == 0) begin
				// b = m*a, c = (m*m/4)*a, disc is zero for even m
				a = 16'($signed($urandom_range(0, 200)) - 100);
				b = 16'($signed($urandom_range(0, 20)) - 10);
				c = 16'((b * b) / 4);
				b = 16'($signed(b) * $signed(a));
				c = 16'($signed(c) * $signed(a));
				b = (b[0]) ? b - 16'd1 : b;
			end else if (r == 1) begin
				a = 16'h0000;
			end
			send_coefs(a, b, c);
		end
		s_tvalid <= 1'b0;
		while (roots_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb_quadratic_root_solver: done, clean");
		else
			$display("tb_quadratic_root_solver: done, errors");
		$finish;
	end
endmodule
